// ===== rtl/assert_macros.svh =====
// Assertion macros used by the page frame allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition that must hold at every rising clock edge outside reset.
`define PFA_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Checks that a consequent holds whenever its antecedent holds.
`define PFA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pfa_pkg.sv =====
// Types and constants shared by the page frame allocator modules.
`default_nettype none

package pfa_pkg;

  localparam int unsigned FRAME_COUNT_DEF = 128;
  localparam int unsigned FRAME_SHIFT_DEF = 21;
  localparam int unsigned COUNT_W         = 8;
  localparam int unsigned ADDR_W          = 28;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY_REQ = 2'd1,
    ST_NO_FRAMES = 2'd2
  } status_e;

  typedef struct packed {
    logic               req_type;
    logic [COUNT_W-1:0] page_count;
    logic [COUNT_W-1:0] chain_head;
  } req_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [COUNT_W-1:0] first_frame;
    logic [ADDR_W-1:0]  first_address;
    logic [COUNT_W-1:0] granted;
  } rsp_word_t;

  // Summary of a finished request, handed to the response formatter.
  typedef struct packed {
    status_e status;
    logic    show_frame;
  } res_info_t;

endpackage

`default_nettype wire

// ===== rtl/pfa_stream_if.sv =====
// Valid/ready channel carrying one word per handshake.
`default_nettype none

interface pfa_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/pfa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module pfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/pfa_fmt.sv =====
// Builds the response word: status, frame index, byte address and grant count.
`default_nettype none

module pfa_fmt import pfa_pkg::*; #(
  parameter int unsigned FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int unsigned FRAME_SHIFT = FRAME_SHIFT_DEF,
  localparam int unsigned LW         = $clog2(FRAME_COUNT + 1)
) (
  input  res_info_t       info_i,
  input  logic [LW-1:0]   head_i,
  input  logic [LW-1:0]   granted_i,
  output rsp_word_t       word_o
);

  localparam int unsigned CW = (LW > COUNT_W) ? LW : COUNT_W;
  localparam int unsigned SW = ADDR_W + LW + FRAME_SHIFT;

  logic [CW-1:0] none_w;
  logic [CW-1:0] frame_w;
  logic [CW-1:0] grant_w;
  logic [SW-1:0] addr_w;

  assign none_w  = CW'(FRAME_COUNT);
  assign frame_w = info_i.show_frame ? CW'(head_i) : none_w;
  assign grant_w = info_i.show_frame ? CW'(granted_i) : '0;
  assign addr_w  = info_i.show_frame ?
                   {{ADDR_W{1'b0}}, head_i, {FRAME_SHIFT{1'b0}}} : '0;

  always_comb begin
    word_o               = '0;
    word_o.status        = info_i.status;
    word_o.first_frame   = frame_w[COUNT_W-1:0];
    word_o.first_address = addr_w[ADDR_W-1:0];
    word_o.granted       = grant_w[COUNT_W-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/page_frame_free_list_allocator.sv =====
// Page frame allocator: free list of fixed-size frames kept in a link RAM.
//
// Requests arrive on req_i (valid/ready); one response word leaves on rsp_o
// for every accepted request word. An allocate detaches up to page_count
// frames from the head of the free list; a free splices the chain that
// starts at chain_head in front of the free list.
//
// After reset the link RAM is initialized one entry per cycle, so req_i.ready
// stays low until every entry of the link RAM is written.
// A request that is rejected, or finds no free frame, goes from acceptance
// straight to the final step that loads the response register. An allocate
// granting n frames, or a free of an n-frame chain, walks n links, at most
// FRAME_COUNT: the walk follows one link per cycle through the single read
// port of the link RAM. One request is in progress at a time, and the next
// one is taken only after the response register loads.
//
// The response sits in an output register; a new request is accepted while
// it waits. A request that finishes while the receiver stalls holds in its
// last step until the output register frees up.
`default_nettype none
`include "assert_macros.svh"

module page_frame_free_list_allocator import pfa_pkg::*; #(
  parameter int unsigned FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int unsigned FRAME_SHIFT = FRAME_SHIFT_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pfa_stream_if.sink    req_i,
  pfa_stream_if.source  rsp_o
);

  localparam int unsigned IW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int unsigned LW = $clog2(FRAME_COUNT + 1);
  localparam int unsigned CW = (LW > COUNT_W) ? LW : COUNT_W;

  typedef enum logic [3:0] {
    S_INIT = 4'b0001,
    S_IDLE = 4'b0010,
    S_WALK = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  state_e        state_q, state_d;
  logic [IW-1:0] init_idx_q, init_idx_d;
  logic [LW-1:0] free_head_q, free_head_d;
  logic [IW-1:0] cur_q, cur_d;
  logic [LW-1:0] cnt_q, cnt_d;
  logic [LW-1:0] nxt_q, nxt_d;
  logic          alloc_q, alloc_d;
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] chain_q, chain_d;
  status_e       status_q, status_d;
  logic          out_valid_q, out_valid_d;
  rsp_word_t     out_word_q;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [LW-1:0] ram_wdata;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  logic [LW-1:0] link;

  logic          acc;
  logic          out_free;
  logic          load_out;
  logic [CW-1:0] count_w;
  logic [CW-1:0] chain_w;
  logic          head_is_frame;
  logic          chain_is_frame;
  logic          link_is_frame;
  logic          nxt_is_frame;
  logic          walk_more;
  res_info_t     info;
  rsp_word_t     fmt_word;

  pfa_ram #(
    .WIDTH (LW),
    .DEPTH (FRAME_COUNT)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (link)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign acc         = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign count_w        = CW'(req_i.data.page_count);
  assign chain_w        = CW'(req_i.data.chain_head);
  assign head_is_frame  = free_head_q < LW'(FRAME_COUNT);
  assign chain_is_frame = chain_w < CW'(FRAME_COUNT);
  assign link_is_frame  = link < LW'(FRAME_COUNT);
  assign nxt_is_frame   = nxt_q < LW'(FRAME_COUNT);

  // Follow another link only while it is a real frame, the walk bound is not
  // reached and, for an allocate, more frames are still wanted.
  assign walk_more = link_is_frame && (cnt_q < LW'(FRAME_COUNT)) &&
                     (!alloc_q || (CW'(cnt_q) < count_q));

  always_comb begin
    state_d     = state_q;
    init_idx_d  = init_idx_q;
    free_head_d = free_head_q;
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    nxt_d       = nxt_q;
    alloc_d     = alloc_q;
    count_d     = count_q;
    chain_d     = chain_q;
    status_d    = status_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    load_out    = 1'b0;

    unique case (state_q)
      S_INIT: begin
        ram_we     = 1'b1;
        ram_waddr  = init_idx_q;
        ram_wdata  = LW'(init_idx_q) + LW'(1);
        init_idx_d = init_idx_q + 1'b1;
        if (init_idx_q == IW'(FRAME_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          alloc_d = (req_i.data.req_type == REQ_ALLOC);
          count_d = count_w;
          chain_d = chain_w[IW-1:0];
          cnt_d   = LW'(1);
          if (req_i.data.req_type == REQ_ALLOC) begin
            if (count_w == '0) begin
              status_d = ST_EMPTY_REQ;
              state_d  = S_FIN;
            end else if (!head_is_frame) begin
              status_d = ST_NO_FRAMES;
              state_d  = S_FIN;
            end else begin
              status_d  = ST_OK;
              ram_re    = 1'b1;
              ram_raddr = free_head_q[IW-1:0];
              cur_d     = free_head_q[IW-1:0];
              state_d   = S_WALK;
            end
          end else begin
            if (!chain_is_frame) begin
              status_d = ST_EMPTY_REQ;
              state_d  = S_FIN;
            end else begin
              status_d  = ST_OK;
              ram_re    = 1'b1;
              ram_raddr = chain_w[IW-1:0];
              cur_d     = chain_w[IW-1:0];
              state_d   = S_WALK;
            end
          end
        end
      end
      S_WALK: begin
        if (walk_more) begin
          ram_re    = 1'b1;
          ram_raddr = link[IW-1:0];
          cur_d     = link[IW-1:0];
          cnt_d     = cnt_q + LW'(1);
        end else begin
          nxt_d   = link;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
          if (status_q == ST_OK) begin
            ram_we    = 1'b1;
            ram_waddr = cur_q;
            if (alloc_q) begin
              // The last granted frame ends the caller's chain.
              ram_wdata   = LW'(FRAME_COUNT);
              free_head_d = nxt_is_frame ? nxt_q : LW'(FRAME_COUNT);
            end else begin
              ram_wdata   = free_head_q;
              free_head_d = LW'(chain_q);
            end
          end
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  assign info.status     = status_q;
  assign info.show_frame = alloc_q && (status_q == ST_OK);

  pfa_fmt #(
    .FRAME_COUNT (FRAME_COUNT),
    .FRAME_SHIFT (FRAME_SHIFT)
  ) u_fmt (
    .info_i    (info),
    .head_i    (free_head_q),
    .granted_i (cnt_q),
    .word_o    (fmt_word)
  );

  assign out_valid_d = load_out || (out_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      init_idx_q  <= '0;
      free_head_q <= '0;
      cnt_q       <= '0;
      alloc_q     <= 1'b0;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_idx_q  <= init_idx_d;
      free_head_q <= free_head_d;
      cnt_q       <= cnt_d;
      alloc_q     <= alloc_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    nxt_q   <= nxt_d;
    count_q <= count_d;
    chain_q <= chain_d;
    if (load_out) begin
      out_word_q <= fmt_word;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_word_q;

  `PFA_ASSERT(a_head_range, free_head_q <= LW'(FRAME_COUNT), "free head out of range")
  `PFA_ASSERT(a_walk_bound, cnt_q <= LW'(FRAME_COUNT), "walk count exceeds frame count")
  `PFA_ASSERT_IMPL(a_no_write_on_accept, ram_we, !acc, "link write collides with accept")
  `PFA_ASSERT_IMPL(a_walk_no_write, state_q == S_WALK, !ram_we, "link write during walk")

endmodule

`default_nettype wire

// ===== test/frame_pool_checker.sv =====
// Checker for the page frame allocator: predicts each response word and compares it.
`timescale 1ns / 1ps

module frame_pool_checker import pfa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  pfa_stream_if       req_mon_i,
  pfa_stream_if       rsp_mon_i,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned dry_o,
  output int unsigned whole_pool_o
);

  localparam int unsigned        NUM_FRAMES = FRAME_COUNT_DEF;
  localparam logic [COUNT_W-1:0] NO_FRAME   = COUNT_W'(NUM_FRAMES);
  localparam int unsigned        MAX_PRINTS = 100;

  logic [COUNT_W-1:0] link_tbl [NUM_FRAMES];
  logic [COUNT_W-1:0] pool_head;
  rsp_word_t          due_rsp [$];

  initial begin
    errors_o     = 0;
    pending_o    = 0;
    checked_o    = 0;
    dry_o        = 0;
    whole_pool_o = 0;
  end

  function automatic bit is_frame(logic [COUNT_W-1:0] f);
    return f < NUM_FRAMES;
  endfunction

  function automatic void reset_pool();
    for (int i = 0; i < NUM_FRAMES; i++) begin
      link_tbl[i] = COUNT_W'(i + 1);
    end
    pool_head = '0;
  endfunction

  // Applies one request to the shadow pool and returns the response it should give.
  function automatic rsp_word_t serve_request(req_word_t rq);
    rsp_word_t          r;
    logic [COUNT_W-1:0] cur;
    int unsigned        granted;
    int unsigned        steps;
    r.status        = ST_OK;
    r.first_frame   = NO_FRAME;
    r.first_address = '0;
    r.granted       = '0;
    steps           = 0;
    if (rq.req_type == REQ_ALLOC) begin
      if (rq.page_count == 0) begin
        r.status = ST_EMPTY_REQ;
      end else if (!is_frame(pool_head)) begin
        r.status = ST_NO_FRAMES;
        dry_o++;
      end else begin
        cur     = pool_head;
        granted = 1;
        while (granted < rq.page_count && steps + 1 < NUM_FRAMES &&
               is_frame(link_tbl[cur])) begin
          cur = link_tbl[cur];
          granted++;
          steps++;
        end
        r.first_frame   = pool_head;
        r.first_address = ADDR_W'(32'(pool_head) << FRAME_SHIFT_DEF);
        r.granted       = COUNT_W'(granted);
        if (granted == NUM_FRAMES) whole_pool_o++;
        pool_head     = is_frame(link_tbl[cur]) ? link_tbl[cur] : NO_FRAME;
        link_tbl[cur] = NO_FRAME;
      end
    end else begin
      if (!is_frame(rq.chain_head)) begin
        r.status = ST_EMPTY_REQ;
      end else begin
        // A cyclic chain stops after the longest legal walk; that frame ends it.
        cur = rq.chain_head;
        while (steps + 1 < NUM_FRAMES && is_frame(link_tbl[cur])) begin
          cur = link_tbl[cur];
          steps++;
        end
        link_tbl[cur] = is_frame(pool_head) ? pool_head : NO_FRAME;
        pool_head     = rq.chain_head;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    errors_o++;
    if (errors_o <= MAX_PRINTS) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  always @(posedge clk_i) begin : watch
    rsp_word_t got;
    rsp_word_t want;
    if (!rst_ni) begin
      reset_pool();
      due_rsp.delete();
    end else begin
      if (rsp_mon_i.valid && rsp_mon_i.ready) begin
        got = rsp_mon_i.data;
        if (due_rsp.size() == 0) begin
          report_mismatch($sformatf("response word %h with no request outstanding", got));
        end else begin
          want = due_rsp.pop_front();
          checked_o++;
          if (got.status != want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
          if (got.first_frame != want.first_frame)
            report_mismatch($sformatf("first_frame %0d, expected %0d",
                                      got.first_frame, want.first_frame));
          if (got.first_address != want.first_address)
            report_mismatch($sformatf("first_address %h, expected %h",
                                      got.first_address, want.first_address));
          if (got.granted != want.granted)
            report_mismatch($sformatf("granted %0d, expected %0d", got.granted, want.granted));
        end
      end
      // A response never leaves in the cycle its request is taken, so order here is safe.
      if (req_mon_i.valid && req_mon_i.ready) begin
        due_rsp.push_back(serve_request(req_mon_i.data));
      end
    end
    pending_o = due_rsp.size();
  end

endmodule

// ===== test/tb.sv =====
// Testbench top for the page frame allocator: drives request words and gives the verdict.
`timescale 1ns / 1ps

module tb;
  import pfa_pkg::*;

  localparam int unsigned NUM_FRAMES   = FRAME_COUNT_DEF;
  localparam int unsigned RAND_ITEMS   = 1040;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 140;

  logic               clk_i;
  logic               rst_ni;
  bit                 idle_ok;
  bit                 hold_req;
  bit                 track_on;
  logic [COUNT_W-1:0] held_heads [$];
  int unsigned        sent;
  int unsigned        errors;
  int unsigned        pending;
  int unsigned        checked;
  int unsigned        dry;
  int unsigned        whole_pool;

  pfa_stream_if #(.word_t(req_word_t)) req_if ();
  pfa_stream_if #(.word_t(rsp_word_t)) rsp_if ();

  page_frame_free_list_allocator u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  frame_pool_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon_i    (req_if),
    .rsp_mon_i    (rsp_if),
    .errors_o     (errors),
    .pending_o    (pending),
    .checked_o    (checked),
    .dry_o        (dry),
    .whole_pool_o (whole_pool)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("page_frame_free_list_allocator test failed");
    $finish;
  end

  // Response side: short random stalls, plus one long hold so the block backs up.
  initial begin : rsp_drain
    rsp_if.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (idle_ok && $urandom_range(0, 4) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        rsp_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Chains handed out by the block, kept so that most frees return real chains.
  always @(posedge clk_i) begin
    if (track_on && rsp_if.valid && rsp_if.ready && rsp_if.data.granted != 0)
      held_heads.push_back(rsp_if.data.first_frame);
  end

  task automatic send_req(input req_type_e kind, input int unsigned cnt,
                          input int unsigned chain);
    req_word_t w;
    w.req_type   = kind;
    w.page_count = COUNT_W'(cnt);
    w.chain_head = COUNT_W'(chain);
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= w;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic wait_drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic free_held();
    int unsigned idx;
    logic [COUNT_W-1:0] head;
    idx  = $urandom_range(0, held_heads.size() - 1);
    head = held_heads[idx];
    held_heads.delete(idx);
    send_req(REQ_FREE, $urandom_range(0, 255), head);
  endtask

  initial begin : stimulus
    int unsigned roll;
    bit          late;
    logic [COUNT_W-1:0] head;
    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    sent         = 0;
    repeat (6) @(posedge clk_i);
    rst_ni  <= 1'b1;
    idle_ok  = 1'b1;

    // Directed words; frame numbers follow from the in-order list after reset.
    send_req(REQ_ALLOC, 0, 0);
    send_req(REQ_FREE, 0, NUM_FRAMES);
    send_req(REQ_FREE, 255, 255);
    send_req(REQ_ALLOC, 1, 0);
    send_req(REQ_ALLOC, 255, 0);
    send_req(REQ_ALLOC, 5, 0);
    send_req(REQ_FREE, 0, 1);
    send_req(REQ_FREE, 0, 0);
    send_req(REQ_ALLOC, NUM_FRAMES, 0);
    send_req(REQ_ALLOC, 1, 0);
    send_req(REQ_FREE, 0, 0);
    send_req(REQ_ALLOC, 3, 0);
    send_req(REQ_ALLOC, 64, 0);
    send_req(REQ_FREE, 0, 0);
    send_req(REQ_ALLOC, 4, 0);
    send_req(REQ_FREE, 0, 3);
    send_req(REQ_FREE, 0, 0);
    wait_drain();
    held_heads.delete();
    track_on = 1'b1;

    for (int i = 0; i < RAND_ITEMS; i++) begin
      idle_ok = (i < RAND_ITEMS - 100) && ((i % 200) < 150);
      late    = i >= RAND_ITEMS - 160;
      if (i == 400) hold_req = 1'b1;
      // Return the same chain twice; the second walk runs into the free list and loops it.
      if (i == RAND_ITEMS - 160) begin
        head = (held_heads.size() != 0) ? held_heads.pop_front() : COUNT_W'(5);
        send_req(REQ_FREE, 0, head);
        send_req(REQ_FREE, 0, head);
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        send_req(REQ_ALLOC, 0, $urandom_range(0, 255));
      end else if (roll < 6) begin
        send_req(REQ_FREE, $urandom_range(0, 255), $urandom_range(NUM_FRAMES, 255));
      end else if (roll < 8) begin
        send_req(REQ_ALLOC, $urandom_range(NUM_FRAMES + 1, 255), $urandom_range(0, 255));
      end else if (late && roll < 14) begin
        send_req(REQ_FREE, $urandom_range(0, 255), $urandom_range(0, NUM_FRAMES - 1));
      end else if (held_heads.size() != 0 && (roll < 52 || held_heads.size() > 24)) begin
        free_held();
      end else if (roll % 10 == 0) begin
        send_req(REQ_ALLOC, $urandom_range(9, NUM_FRAMES), $urandom_range(0, 255));
      end else begin
        send_req(REQ_ALLOC, $urandom_range(1, 8), $urandom_range(0, 255));
      end
    end

    idle_ok = 1'b0;
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d request words, checked %0d responses; the pool ran dry %0d times.",
             sent, checked, dry);
    $display("%0d allocations took every frame; a %0d-cycle response stall and double frees ran.",
             whole_pool, LONG_HOLD);
    if (errors == 0) begin
      $display("page_frame_free_list_allocator test passed");
    end else begin
      $display("page_frame_free_list_allocator test failed");
    end
    $finish;
  end

endmodule
